@@ hw/rtl/udpck_pkg.sv @@
// Shared types and constants for the UDP header parse and checksum verify block.
package udpck_pkg;

  localparam int unsigned MAX_BYTES_DEFAULT = 65535;
  // Width that holds any byte count or length for compares
  localparam int unsigned CMP_W = 17;
  localparam logic [15:0] UDP_PROTO = 16'd17;
  localparam logic [15:0] HDR_BYTES = 16'd8;

  typedef enum logic [1:0] {
    STATUS_OK   = 2'd0,
    STATUS_BAD  = 2'd1,
    STATUS_CSUM = 2'd2
  } udpck_status_t;

  // Per-datagram state kept between bytes
  typedef struct packed {
    logic [15:0] sum;
    logic [7:0]  held;
    logic [15:0] sport;
    logic [15:0] dport;
    logic [15:0] len;
    logic [15:0] csum;
  } udpck_hdr_t;

  typedef struct packed {
    udpck_status_t status;
    logic [15:0]   sport;
    logic [15:0]   dport;
    logic [15:0]   len;
    logic [15:0]   csum;
    logic [15:0]   pay;
  } udpck_result_t;

endpackage

@@ hw/rtl/udp_header_parse_checksum_verify_core.sv @@
// Top level of the UDP header parse and checksum verify block.
//
//   channel | handshake                     | payload
//   --------+-------------------------------+--------------------------------------------
//   in      | in_valid / in_stall  (input)  | data_byte, first_byte, last_byte,
//           |                               | source_address, destination_address
//   out     | out_valid / out_stall (output)| status, source_port, destination_port,
//           |                               | length_field, checksum_field, payload_length
//
// One byte request is taken every cycle unless in_stall holds it; the running ones'-complement
// add per byte is the loop that sets this rate. A result is registered when its last byte leaves the input stage.
// Synchronous active-high reset clears the input and result stages and all datagram state.
// A held result stalls the input stage only when the next byte is also a last byte.
module udp_header_parse_checksum_verify_core
  import udpck_pkg::*;
#(
  parameter int unsigned MAX_BYTES = MAX_BYTES_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        first_byte,
  input  logic        last_byte,
  input  logic [31:0] source_address,
  input  logic [31:0] destination_address,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic [15:0] source_port,
  output logic [15:0] destination_port,
  output logic [15:0] length_field,
  output logic [15:0] checksum_field,
  output logic [15:0] payload_length
);

  localparam int unsigned CNT_W = $clog2(MAX_BYTES + 2);

  logic             s1_valid;
  logic [7:0]       s1_data;
  logic             s1_first;
  logic             s1_last;
  logic [31:0]      s1_sa;
  logic [31:0]      s1_da;
  logic [CNT_W-1:0] byte_counter;
  udpck_hdr_t       hdr;
  logic [CNT_W-1:0] count_next;
  udpck_hdr_t       hdr_next;
  udpck_result_t    step_result;
  udpck_result_t    res;
  logic             advance;
  logic             accept;

  udpck_step #(
    .MAX_BYTES(MAX_BYTES)
  ) u_step (
    .count               (byte_counter),
    .hdr                 (hdr),
    .data_byte           (s1_data),
    .first_byte          (s1_first),
    .last_byte           (s1_last),
    .source_address      (s1_sa),
    .destination_address (s1_da),
    .count_next          (count_next),
    .hdr_next            (hdr_next),
    .result              (step_result)
  );

  // A byte that makes no result always moves on; a last byte needs room in the result stage
  assign advance  = s1_valid && (!s1_last || !out_valid || !out_stall);
  assign in_stall = s1_valid && !advance;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      out_valid    <= 1'b0;
      byte_counter <= '0;
      hdr          <= '0;
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (advance) begin
        s1_valid <= 1'b0;
      end
      if (advance) begin
        byte_counter <= count_next;
        hdr          <= hdr_next;
      end
      if (advance && s1_last) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_data  <= data_byte;
      s1_first <= first_byte;
      s1_last  <= last_byte;
      s1_sa    <= source_address;
      s1_da    <= destination_address;
    end
    if (advance && s1_last) begin
      res <= step_result;
    end
  end

  assign status           = res.status;
  assign source_port      = res.sport;
  assign destination_port = res.dport;
  assign length_field     = res.len;
  assign checksum_field   = res.csum;
  assign payload_length   = res.pay;

`ifndef SYNTHESIS
  a_ok_payload : assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == STATUS_OK) |-> payload_length == length_field - HDR_BYTES)
    else $error("payload length does not follow length field on good datagram");

  a_bad_payload : assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != STATUS_OK) |-> payload_length == 16'h0000)
    else $error("payload length nonzero on rejected datagram");

  a_csum_nonzero : assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == STATUS_CSUM) |-> checksum_field != 16'h0000)
    else $error("checksum mismatch reported with zero checksum field");

  a_count_sat : assert property (@(posedge clk) disable iff (rst)
    CMP_W'(byte_counter) <= CMP_W'(MAX_BYTES + 1))
    else $error("byte counter past saturation");
`endif

endmodule

@@ hw/rtl/udpck_step.sv @@
// Per-byte header capture, ones'-complement sum update and end-of-datagram verdict.
module udpck_step
  import udpck_pkg::*;
#(
  parameter int unsigned MAX_BYTES = MAX_BYTES_DEFAULT,
  localparam int unsigned CNT_W = $clog2(MAX_BYTES + 2)
) (
  input  logic [CNT_W-1:0] count,
  input  udpck_hdr_t       hdr,
  input  logic [7:0]       data_byte,
  input  logic             first_byte,
  input  logic             last_byte,
  input  logic [31:0]      source_address,
  input  logic [31:0]      destination_address,
  output logic [CNT_W-1:0] count_next,
  output udpck_hdr_t       hdr_next,
  output udpck_result_t    result
);

  // Bytes before this index are always summed; length field is complete from this index on
  localparam logic [CMP_W-1:0] LEN_DONE = CMP_W'(6);

  logic [CNT_W-1:0] idx;
  logic [CNT_W-1:0] cnt;
  logic [CMP_W-1:0] idx_w;
  logic [CMP_W-1:0] n_w;
  logic [CMP_W-1:0] len_w;
  udpck_hdr_t       base;
  udpck_hdr_t       cur;
  logic             include_byte;
  logic             add_word;
  logic [15:0]      word;
  logic [17:0]      asum;
  logic [16:0]      afold1;
  logic [15:0]      afold;
  logic [16:0]      wsum;
  logic [15:0]      wfold;
  logic [15:0]      pad;
  logic [18:0]      tot;
  logic [16:0]      tfold1;
  logic [15:0]      tfold;

  always_comb begin
    base  = first_byte ? '0 : hdr;
    idx   = first_byte ? '0 : count;
    idx_w = CMP_W'(idx);

    // Saturate at one past the largest accepted datagram
    if (idx_w <= CMP_W'(MAX_BYTES)) begin
      cnt = CNT_W'(idx + 1'b1);
    end else begin
      cnt = idx;
    end

    cur = base;
    if (idx_w < CMP_W'(HDR_BYTES)) begin
      case (idx[2:0])
        3'd0: cur.sport    = {data_byte, 8'h00};
        3'd1: cur.sport    = {base.sport[15:8], data_byte};
        3'd2: cur.dport    = {data_byte, 8'h00};
        3'd3: cur.dport    = {base.dport[15:8], data_byte};
        3'd4: cur.len      = {data_byte, 8'h00};
        3'd5: cur.len      = {base.len[15:8], data_byte};
        3'd6: cur.csum     = {data_byte, 8'h00};
        3'd7: cur.csum     = {base.csum[15:8], data_byte};
        default: cur.csum  = base.csum;
      endcase
    end

    include_byte = (idx_w < LEN_DONE) || (idx_w < CMP_W'(base.len));
    add_word     = include_byte && idx[0];
    word         = {base.held, data_byte};

    if (include_byte) begin
      cur.held = idx[0] ? 8'h00 : data_byte;
    end

    // Pseudo-header addresses seed the sum on the first byte
    asum   = 18'(source_address[31:16]) + 18'(source_address[15:0])
           + 18'(destination_address[31:16]) + 18'(destination_address[15:0]);
    afold1 = 17'(asum[15:0]) + 17'(asum[17:16]);
    afold  = afold1[15:0] + 16'(afold1[16]);

    wsum  = 17'(base.sum) + 17'(word);
    wfold = wsum[15:0] + 16'(wsum[16]);

    if (first_byte) begin
      cur.sum = afold;
    end else if (add_word) begin
      cur.sum = wfold;
    end

    // Final check folds word, odd pad, protocol and length in one pass
    pad    = cur.len[0] ? {cur.held, 8'h00} : 16'h0000;
    tot    = 19'(base.sum) + (add_word ? 19'(word) : 19'd0) + 19'(pad)
           + 19'(UDP_PROTO) + 19'(cur.len);
    tfold1 = 17'(tot[15:0]) + 17'(tot[18:16]);
    tfold  = tfold1[15:0] + 16'(tfold1[16]);

    n_w   = CMP_W'(cnt);
    len_w = CMP_W'(cur.len);

    result.sport = cur.sport;
    result.dport = cur.dport;
    result.len   = cur.len;
    result.csum  = cur.csum;
    result.pay   = 16'h0000;
    if (n_w < CMP_W'(HDR_BYTES)) begin
      result.status = STATUS_BAD;
      result.sport  = 16'h0000;
      result.dport  = 16'h0000;
      result.len    = 16'h0000;
      result.csum   = 16'h0000;
    end else if ((n_w > CMP_W'(MAX_BYTES)) || (cur.len < HDR_BYTES) || (len_w > n_w)) begin
      result.status = STATUS_BAD;
    end else if ((cur.csum != 16'h0000) && (tfold != 16'hFFFF)) begin
      result.status = STATUS_CSUM;
    end else begin
      result.status = STATUS_OK;
      result.pay    = cur.len - HDR_BYTES;
    end

    // Drop all datagram state after the last byte
    if (last_byte) begin
      hdr_next   = '0;
      count_next = '0;
    end else begin
      hdr_next   = cur;
      count_next = cnt;
    end
  end

endmodule

@@ verif/udp_datagram_checker.sv @@
// Checker for the UDP parse core: tracks accepted bytes, predicts each report and compares it.
`timescale 1ns / 100ps
module udp_datagram_checker
  import udpck_pkg::*;
#(
  parameter int unsigned MAX_BYTES = MAX_BYTES_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        first_byte,
  input  logic        last_byte,
  input  logic [31:0] source_address,
  input  logic [31:0] destination_address,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [1:0]  status,
  input  logic [15:0] source_port,
  input  logic [15:0] destination_port,
  input  logic [15:0] length_field,
  input  logic [15:0] checksum_field,
  input  logic [15:0] payload_length,
  output int          error_count,
  output int          pending
);

  logic [16:0] byte_cnt;
  logic [15:0] sum_acc;
  logic [7:0]  held_byte;
  logic [15:0] hdr_sport;
  logic [15:0] hdr_dport;
  logic [15:0] hdr_len;
  logic [15:0] hdr_csum;

  udpck_result_t expected_reports[$];

  function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[15:0] + {15'd0, s[16]};
  endfunction

  task automatic clear_datagram();
    byte_cnt  = '0;
    sum_acc   = '0;
    held_byte = '0;
    hdr_sport = '0;
    hdr_dport = '0;
    hdr_len   = '0;
    hdr_csum  = '0;
  endtask

  task automatic close_datagram();
    udpck_result_t r;
    logic [15:0] s;
    r = '0;
    r.status = STATUS_OK;
    if (byte_cnt < 17'd8) begin
      // too short: header fields reported as zero
      r.status = STATUS_BAD;
    end else begin
      r.sport = hdr_sport;
      r.dport = hdr_dport;
      r.len   = hdr_len;
      r.csum  = hdr_csum;
      if (byte_cnt > MAX_BYTES || hdr_len < HDR_BYTES || {1'b0, hdr_len} > byte_cnt) begin
        r.status = STATUS_BAD;
      end else begin
        if (hdr_csum != 16'd0) begin
          s = sum_acc;
          // pad an odd trailing byte with zero
          if (hdr_len[0]) s = ones_add(s, {held_byte, 8'h00});
          s = ones_add(s, UDP_PROTO);
          s = ones_add(s, hdr_len);
          if (s != 16'hFFFF) r.status = STATUS_CSUM;
        end
        if (r.status == STATUS_OK) r.pay = hdr_len - HDR_BYTES;
      end
    end
    expected_reports.push_back(r);
    clear_datagram();
  endtask

  task automatic absorb_byte(input logic [7:0] b, input logic fb, input logic lb,
                             input logic [31:0] sa, input logic [31:0] da);
    logic [16:0] idx;
    if (fb) begin
      clear_datagram();
      sum_acc = ones_add(sum_acc, sa[31:16]);
      sum_acc = ones_add(sum_acc, sa[15:0]);
      sum_acc = ones_add(sum_acc, da[31:16]);
      sum_acc = ones_add(sum_acc, da[15:0]);
    end
    idx = byte_cnt;
    case (idx)
      17'd0: hdr_sport = {b, 8'h00};
      17'd1: hdr_sport = hdr_sport | {8'h00, b};
      17'd2: hdr_dport = {b, 8'h00};
      17'd3: hdr_dport = hdr_dport | {8'h00, b};
      17'd4: hdr_len   = {b, 8'h00};
      17'd5: hdr_len   = hdr_len | {8'h00, b};
      17'd6: hdr_csum  = {b, 8'h00};
      17'd7: hdr_csum  = hdr_csum | {8'h00, b};
      default: ;
    endcase
    // sum everything until the length is known, then only bytes inside it
    if (idx < 17'd6 || idx < {1'b0, hdr_len}) begin
      if (!idx[0]) begin
        held_byte = b;
      end else begin
        sum_acc   = ones_add(sum_acc, {held_byte, b});
        held_byte = '0;
      end
    end
    if (byte_cnt <= MAX_BYTES) byte_cnt = byte_cnt + 17'd1;
    if (lb) close_datagram();
  endtask

  always @(posedge clk) begin : watch
    udpck_result_t want;
    if (rst) begin
      clear_datagram();
      expected_reports.delete();
      error_count = 0;
    end else begin
      if (in_valid && !in_stall) begin
        absorb_byte(data_byte, first_byte, last_byte, source_address, destination_address);
      end
      if (out_valid && !out_stall) begin
        if (expected_reports.size() == 0) begin
          error_count++;
          if (error_count <= 10) $display("%0t: report with no datagram pending", $time);
        end else begin
          want = expected_reports.pop_front();
          if (status !== want.status || source_port !== want.sport ||
              destination_port !== want.dport || length_field !== want.len ||
              checksum_field !== want.csum || payload_length !== want.pay) begin
            error_count++;
            if (error_count <= 10) begin
              $display("%0t: report mismatch: expected st %0d sp %h dp %h len %h cs %h pay %h",
                       $time, want.status, want.sport, want.dport, want.len,
                       want.csum, want.pay);
              $display("%0t:                  actual st %0d sp %h dp %h len %h cs %h pay %h",
                       $time, status, source_port, destination_port, length_field,
                       checksum_field, payload_length);
            end
          end
        end
      end
    end
    pending = expected_reports.size();
  end

endmodule

@@ verif/udp_header_parse_checksum_verify_core_tb.sv @@
// Testbench top for the UDP parse core: builds datagrams, drives bytes and gives the verdict.
`timescale 1ns / 100ps
module udp_header_parse_checksum_verify_core_tb
  import udpck_pkg::*;
();

  localparam int unsigned MAX_BYTES = MAX_BYTES_DEFAULT;
  localparam int IDLE_LIMIT = 2000;
  localparam int RANDOM_BYTES = 1850;

  logic        clk = 1'b0;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  data_byte;
  logic        first_byte;
  logic        last_byte;
  logic [31:0] source_address;
  logic [31:0] destination_address;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  status;
  logic [15:0] source_port;
  logic [15:0] destination_port;
  logic [15:0] length_field;
  logic [15:0] checksum_field;
  logic [15:0] payload_length;
  int          error_count;
  int          pending;

  int          idle_cycles;
  int          bytes_sent;
  int          gap_pct;
  logic [7:0]  pkt[$];
  logic [31:0] pkt_sa;
  logic [31:0] pkt_da;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  udp_header_parse_checksum_verify_core #(.MAX_BYTES(MAX_BYTES)) u_top (.*);

  udp_datagram_checker #(.MAX_BYTES(MAX_BYTES)) u_check (.*);

  function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[15:0] + {15'd0, s[16]};
  endfunction

  // Mostly short gaps, now and then a long one
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  task automatic drive_byte(input logic [7:0] b, input logic fb, input logic lb,
                            input logic [31:0] sa, input logic [31:0] da);
    in_valid            <= 1'b1;
    data_byte           <= b;
    first_byte          <= fb;
    last_byte           <= lb;
    source_address      <= sa;
    destination_address <= da;
    do @(posedge clk); while (in_stall);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic maybe_idle();
    int n;
    if (gap_pct != 0 && $urandom_range(1, 100) <= gap_pct) begin
      n = gap_len();
      in_valid <= 1'b0;
      repeat (n) @(negedge clk);
    end
  endtask

  // Header with zero checksum, then random bytes up to total_n
  task automatic build_pkt(input logic [15:0] sport, input logic [15:0] dport,
                           input logic [15:0] lenf, input int total_n);
    pkt.delete();
    pkt.push_back(sport[15:8]);
    pkt.push_back(sport[7:0]);
    pkt.push_back(dport[15:8]);
    pkt.push_back(dport[7:0]);
    pkt.push_back(lenf[15:8]);
    pkt.push_back(lenf[7:0]);
    pkt.push_back(8'h00);
    pkt.push_back(8'h00);
    while (pkt.size() < total_n) pkt.push_back(8'($urandom_range(0, 255)));
  endtask

  task automatic random_pkt(input int n);
    pkt.delete();
    repeat (n) pkt.push_back(8'($urandom_range(0, 255)));
  endtask

  // Fill in a correct checksum over the first lenf bytes
  task automatic seal_pkt(input logic use_addr);
    logic [15:0] s;
    logic [15:0] lenf;
    logic [31:0] sa;
    logic [31:0] da;
    lenf = {pkt[4], pkt[5]};
    sa = use_addr ? pkt_sa : 32'd0;
    da = use_addr ? pkt_da : 32'd0;
    pkt[6] = 8'h00;
    pkt[7] = 8'h00;
    s = ones_add(16'd0, sa[31:16]);
    s = ones_add(s, sa[15:0]);
    s = ones_add(s, da[31:16]);
    s = ones_add(s, da[15:0]);
    s = ones_add(s, UDP_PROTO);
    s = ones_add(s, lenf);
    for (int i = 0; i < lenf; i += 2) begin
      s = ones_add(s, {pkt[i], (i + 1 < lenf) ? pkt[i + 1] : 8'h00});
    end
    s = ~s;
    if (s == 16'd0) s = 16'hFFFF;
    pkt[6] = s[15:8];
    pkt[7] = s[7:0];
  endtask

  task automatic send_pkt(input logic mark_first);
    for (int i = 0; i < pkt.size(); i++) begin
      maybe_idle();
      // addresses off the first byte are junk and must be ignored
      drive_byte(pkt[i], mark_first && i == 0, i == pkt.size() - 1,
                 (mark_first && i == 0) ? pkt_sa : $urandom(),
                 (mark_first && i == 0) ? pkt_da : $urandom());
    end
  endtask

  // Stray marks, back-to-back last bytes
  task automatic send_noise(input int n);
    for (int i = 0; i < n; i++) begin
      maybe_idle();
      drive_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                 (i == n - 1) || ($urandom_range(0, 2) == 0), $urandom(), $urandom());
    end
  endtask

  task automatic random_datagram();
    int kind;
    int body;
    int total;
    int pos;
    logic [15:0] lenf;
    kind   = $urandom_range(0, 99);
    pkt_sa = ($urandom_range(0, 15) == 0) ? '1 : $urandom();
    pkt_da = ($urandom_range(0, 15) == 0) ? '0 : $urandom();
    body   = ($urandom_range(0, 9) == 0) ? $urandom_range(41, 300) : $urandom_range(0, 40);
    total  = 8 + body + (($urandom_range(0, 6) == 0) ? $urandom_range(1, 5) : 0);
    gap_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 40);
    if (kind < 45) begin
      build_pkt(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                16'(8 + body), total);
      seal_pkt(1'b1);
      send_pkt(1'b1);
    end else if (kind < 55) begin
      build_pkt(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                16'(8 + body), total);
      send_pkt(1'b1);
    end else if (kind < 65) begin
      build_pkt(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                16'(8 + body), total);
      seal_pkt(1'b1);
      pos = $urandom_range(0, 7 + body);
      pkt[pos] = pkt[pos] ^ (8'h01 << $urandom_range(0, 7));
      send_pkt(1'b1);
    end else if (kind < 73) begin
      lenf = $urandom_range(0, 1) ? 16'($urandom_range(0, 7))
                                  : 16'($urandom_range(total + 1, 65535));
      build_pkt(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)), lenf, total);
      pkt[6] = 8'($urandom_range(0, 255));
      pkt[7] = 8'($urandom_range(0, 255));
      send_pkt(1'b1);
    end else if (kind < 81) begin
      random_pkt($urandom_range(1, 7));
      send_pkt(1'b1);
    end else if (kind < 87) begin
      build_pkt(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                16'(8 + body), total);
      seal_pkt(1'b0);
      send_pkt(1'b0);
    end else if (kind < 95) begin
      random_pkt($urandom_range(8, 30));
      send_pkt(1'b1);
    end else begin
      send_noise($urandom_range(2, 12));
    end
  endtask

  initial begin
    out_stall <= 1'b0;
    @(negedge rst);
    forever begin
      out_stall <= 1'b1;
      repeat (gap_len()) @(negedge clk);
      out_stall <= 1'b0;
      repeat (($urandom_range(0, 5) == 0) ? $urandom_range(30, 150) : $urandom_range(1, 4))
        @(negedge clk);
    end
  end

  // End the run when neither channel moves for too long
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("udp_header_parse_checksum_verify_core_tb: FAIL");
        $finish;
      end
    end
  end

  initial begin
    rst                 <= 1'b1;
    in_valid            <= 1'b0;
    data_byte           <= '0;
    first_byte          <= 1'b0;
    last_byte           <= 1'b0;
    source_address      <= '0;
    destination_address <= '0;
    bytes_sent          = 0;
    gap_pct             = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // no first mark right after reset: addresses count as zero
    pkt_sa = '1;
    pkt_da = '1;
    build_pkt(16'hFFFF, 16'h0000, 16'd11, 11);
    seal_pkt(1'b0);
    send_pkt(1'b0);
    // both marks on one byte
    random_pkt(1);
    pkt[0] = 8'hFF;
    send_pkt(1'b1);
    // seven bytes: too short
    random_pkt(7);
    send_pkt(1'b1);
    // header only, checksum field zero so no verification
    pkt_sa = '1;
    pkt_da = '0;
    build_pkt(16'h0000, 16'h0000, 16'd8, 8);
    send_pkt(1'b1);
    // header only, verified
    pkt_sa = '0;
    pkt_da = '1;
    build_pkt(16'hFFFF, 16'hFFFF, 16'd8, 8);
    seal_pkt(1'b1);
    send_pkt(1'b1);
    // length field below eight
    build_pkt(16'h0001, 16'h0002, 16'd7, 10);
    send_pkt(1'b1);
    // length field past the bytes received
    build_pkt(16'h0003, 16'h0004, 16'hFFFF, 12);
    pkt[7] = 8'h5A;
    send_pkt(1'b1);
    // odd length with trailing bytes beyond it
    gap_pct = 25;
    pkt_sa = $urandom();
    pkt_da = $urandom();
    build_pkt(16'h8000, 16'h00FF, 16'd13, 16);
    seal_pkt(1'b1);
    send_pkt(1'b1);
    // damaged payload
    build_pkt(16'h1234, 16'h5678, 16'd20, 20);
    seal_pkt(1'b1);
    pkt[12] = pkt[12] ^ 8'h80;
    send_pkt(1'b1);

    while (bytes_sent < RANDOM_BYTES) random_datagram();

    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (error_count == 0) begin
      $display("udp_header_parse_checksum_verify_core_tb: PASS");
    end else begin
      $display("udp_header_parse_checksum_verify_core_tb: FAIL");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hw/rtl/udpck_pkg.sv
hw/rtl/udpck_step.sv
hw/rtl/udp_header_parse_checksum_verify_core.sv
verif/udp_datagram_checker.sv
verif/udp_header_parse_checksum_verify_core_tb.sv
